// ===== rtl/dcsh_pkg.sv =====
// dcsh_pkg: shared types, constants and helpers of the dual-channel sample histogram
// depends on nothing; used by the channel interfaces and the top level
`default_nettype none

package dcsh_pkg;

    // sample and result field widths
    localparam int SAMPLE_W   = 16;
    localparam int PAIR_W     = 40;
    localparam int BIN_OUT_W  = 32;

    // histogram geometry
    localparam int BIN_COUNT   = 65536;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_ADDR_W  = $clog2(BIN_COUNT);

    // operation codes
    localparam logic OP_PAIR = 1'b0;
    localparam logic OP_READ = 1'b1;

    // channel select codes
    localparam logic CHAN_EVEN = 1'b0;
    localparam logic CHAN_ODD  = 1'b1;

    // empty-extreme values
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [BIN_ADDR_W-1:0]  bin_addr_t;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] even_sample;
        logic signed [SAMPLE_W-1:0] odd_sample;
        logic [SAMPLE_W-1:0]        read_bin;
        logic                       read_channel;
    } dcsh_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] even_min;
        logic signed [SAMPLE_W-1:0] even_max;
        logic signed [SAMPLE_W-1:0] odd_min;
        logic signed [SAMPLE_W-1:0] odd_max;
        logic [PAIR_W-1:0]          pairs_seen;
        logic [BIN_OUT_W-1:0]       bin_count;
    } dcsh_out_t;

    // offset-binary code of a sample: sign bit flipped
    function automatic logic [SAMPLE_W-1:0] offset_code(logic signed [SAMPLE_W-1:0] s);
        return {~s[SAMPLE_W-1], s[SAMPLE_W-2:0]};
    endfunction

    // true when the code names an existing bin
    function automatic logic code_in_range(logic [SAMPLE_W-1:0] code);
        return (32'(code) < 32'(BIN_COUNT));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dcsh_if.sv =====
// dcsh_in_if / dcsh_out_if: valid-ready channels carrying one item each
// depends on dcsh_pkg for the payload structs
`default_nettype none

interface dcsh_in_if;
    logic               valid;
    logic               ready;
    dcsh_pkg::dcsh_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dcsh_out_if;
    logic                valid;
    logic                ready;
    dcsh_pkg::dcsh_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/dual_channel_sample_histogram.sv =====
// dual_channel_sample_histogram: running min/max, pair count and per-code histograms
// depends on dcsh_pkg and the channel interfaces in dcsh_if.sv
`default_nettype none

// One item per clock cycle in steady state unless the output stalls; an item's
// result passes through stage 1 and then into the output register. Each histogram
// is a single-port-write, registered-read memory of BIN_COUNT counters: the bin is
// read when the item is accepted and incremented and written back when it leaves
// stage 1, with the last write forwarded so that equal codes in consecutive items
// count correctly. After reset the block walks both memories once to zero them;
// in_ch.ready stays low during that pass, while the histogram_enable register can
// be written at any time. A read item reports the bin of the chosen channel as it
// stands after all earlier items, saturated to 32 bits.
module dual_channel_sample_histogram (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_wr_en,
    input  wire logic  cfg_wr_data,
    dcsh_in_if.sink    in_ch,
    dcsh_out_if.source out_ch
);
    import dcsh_pkg::*;

    // configuration
    logic hist_enable_reg;

    // clearing pass
    logic      clr_active_reg;
    bin_addr_t clr_idx_reg;

    // running statistics
    logic signed [SAMPLE_W-1:0] even_low_reg, even_low_next;
    logic signed [SAMPLE_W-1:0] even_high_reg, even_high_next;
    logic signed [SAMPLE_W-1:0] odd_low_reg, odd_low_next;
    logic signed [SAMPLE_W-1:0] odd_high_reg, odd_high_next;
    logic [PAIR_W-1:0]          pair_total_reg, pair_total_next;

    // memories and their read ports
    count_t even_mem [BIN_COUNT];
    count_t odd_mem  [BIN_COUNT];
    count_t even_rdata_reg;
    count_t odd_rdata_reg;

    // stage 1: item whose bins are on the read ports
    logic                       s1_valid_reg;
    logic                       s1_op_reg;
    logic                       s1_chan_reg;
    logic                       s1_rd_ok_reg;
    logic                       s1_inc_even_reg;
    logic                       s1_inc_odd_reg;
    bin_addr_t                  s1_even_addr_reg;
    bin_addr_t                  s1_odd_addr_reg;
    logic signed [SAMPLE_W-1:0] s1_even_min_reg;
    logic signed [SAMPLE_W-1:0] s1_even_max_reg;
    logic signed [SAMPLE_W-1:0] s1_odd_min_reg;
    logic signed [SAMPLE_W-1:0] s1_odd_max_reg;
    logic [PAIR_W-1:0]          s1_pairs_reg;

    // last increment written to each memory, for forwarding
    logic      fwd_even_valid_reg;
    bin_addr_t fwd_even_addr_reg;
    count_t    fwd_even_data_reg;
    logic      fwd_odd_valid_reg;
    bin_addr_t fwd_odd_addr_reg;
    count_t    fwd_odd_data_reg;

    // output register
    logic      out_valid_reg;
    dcsh_out_t out_payload_reg;

    // handshake and stage-0 decode
    logic                accept;
    logic                s1_move;
    logic                is_pair;
    logic [SAMPLE_W-1:0] even_code;
    logic [SAMPLE_W-1:0] odd_code;
    logic [SAMPLE_W-1:0] rd_code;
    bin_addr_t           even_raddr;
    bin_addr_t           odd_raddr;

    // stage-1 arithmetic
    count_t               even_cur;
    count_t               odd_cur;
    count_t               even_inc;
    count_t               odd_inc;
    count_t               sel_cnt;
    logic [63:0]          sel_wide;
    logic [BIN_OUT_W-1:0] bin_value;

    // memory write ports
    logic      even_we;
    bin_addr_t even_waddr;
    count_t    even_wdata;
    logic      odd_we;
    bin_addr_t odd_waddr;
    count_t    odd_wdata;

    // handshake
    assign s1_move     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !clr_active_reg && (!s1_valid_reg || s1_move);
    assign accept      = in_ch.valid && in_ch.ready;

    // stage-0 decode and read addresses
    always_comb
    begin
        is_pair    = (in_ch.payload.op == OP_PAIR);
        even_code  = offset_code(in_ch.payload.even_sample);
        odd_code   = offset_code(in_ch.payload.odd_sample);
        rd_code    = in_ch.payload.read_bin;
        even_raddr = is_pair ? even_code[BIN_ADDR_W-1:0] : rd_code[BIN_ADDR_W-1:0];
        odd_raddr  = is_pair ? odd_code[BIN_ADDR_W-1:0] : rd_code[BIN_ADDR_W-1:0];
    end

    // next running statistics for a pair item
    always_comb
    begin
        even_low_next   = even_low_reg;
        even_high_next  = even_high_reg;
        odd_low_next    = odd_low_reg;
        odd_high_next   = odd_high_reg;
        pair_total_next = pair_total_reg;
        if (is_pair)
        begin
            if (in_ch.payload.even_sample < even_low_reg)
                even_low_next = in_ch.payload.even_sample;
            if (in_ch.payload.even_sample > even_high_reg)
                even_high_next = in_ch.payload.even_sample;
            if (in_ch.payload.odd_sample < odd_low_reg)
                odd_low_next = in_ch.payload.odd_sample;
            if (in_ch.payload.odd_sample > odd_high_reg)
                odd_high_next = in_ch.payload.odd_sample;
            if (pair_total_reg != '1)
                pair_total_next = pair_total_reg + PAIR_W'(1);
        end
    end

    // stage-1 counts with forwarding and saturating increment
    always_comb
    begin
        even_cur = (fwd_even_valid_reg && fwd_even_addr_reg == s1_even_addr_reg)
                   ? fwd_even_data_reg : even_rdata_reg;
        odd_cur  = (fwd_odd_valid_reg && fwd_odd_addr_reg == s1_odd_addr_reg)
                   ? fwd_odd_data_reg : odd_rdata_reg;
        even_inc = (even_cur == '1) ? even_cur : even_cur + COUNT_WIDTH'(1);
        odd_inc  = (odd_cur == '1) ? odd_cur : odd_cur + COUNT_WIDTH'(1);
        sel_cnt  = (s1_chan_reg == CHAN_ODD) ? odd_cur : even_cur;
        sel_wide = 64'(sel_cnt);
        if (s1_op_reg != OP_READ || !s1_rd_ok_reg)
            bin_value = '0;
        else if (sel_wide > 64'h0000_0000_FFFF_FFFF)
            bin_value = '1;
        else
            bin_value = sel_wide[BIN_OUT_W-1:0];
    end

    // memory write ports: clearing pass or write-back
    always_comb
    begin
        even_we    = clr_active_reg || (s1_move && s1_inc_even_reg);
        odd_we     = clr_active_reg || (s1_move && s1_inc_odd_reg);
        even_waddr = clr_active_reg ? clr_idx_reg : s1_even_addr_reg;
        odd_waddr  = clr_active_reg ? clr_idx_reg : s1_odd_addr_reg;
        even_wdata = clr_active_reg ? '0 : even_inc;
        odd_wdata  = clr_active_reg ? '0 : odd_inc;
    end

    // histogram memories
    always_ff @(posedge clk)
    begin
        if (even_we)
            even_mem[even_waddr] <= even_wdata;
        if (accept)
            even_rdata_reg <= even_mem[even_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (odd_we)
            odd_mem[odd_waddr] <= odd_wdata;
        if (accept)
            odd_rdata_reg <= odd_mem[odd_raddr];
    end

    // configuration, clearing pass and running statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_enable_reg <= 1'b0;
            clr_active_reg  <= 1'b1;
            clr_idx_reg     <= '0;
            even_low_reg    <= SAMPLE_MAX;
            even_high_reg   <= SAMPLE_MIN;
            odd_low_reg     <= SAMPLE_MAX;
            odd_high_reg    <= SAMPLE_MIN;
            pair_total_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                hist_enable_reg <= cfg_wr_data;
            if (clr_active_reg)
            begin
                clr_idx_reg <= clr_idx_reg + BIN_ADDR_W'(1);
                if (clr_idx_reg == BIN_ADDR_W'(BIN_COUNT - 1))
                    clr_active_reg <= 1'b0;
            end
            if (accept)
            begin
                even_low_reg   <= even_low_next;
                even_high_reg  <= even_high_next;
                odd_low_reg    <= odd_low_next;
                odd_high_reg   <= odd_high_next;
                pair_total_reg <= pair_total_next;
            end
        end
    end

    // stage-1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    // stage-1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg        <= in_ch.payload.op;
            s1_chan_reg      <= in_ch.payload.read_channel;
            s1_rd_ok_reg     <= code_in_range(rd_code);
            s1_inc_even_reg  <= is_pair && hist_enable_reg && code_in_range(even_code);
            s1_inc_odd_reg   <= is_pair && hist_enable_reg && code_in_range(odd_code);
            s1_even_addr_reg <= even_raddr;
            s1_odd_addr_reg  <= odd_raddr;
            s1_even_min_reg  <= even_low_next;
            s1_even_max_reg  <= even_high_next;
            s1_odd_min_reg   <= odd_low_next;
            s1_odd_max_reg   <= odd_high_next;
            s1_pairs_reg     <= pair_total_next;
        end
    end

    // forwarding registers track the latest increment of each memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_even_valid_reg <= 1'b0;
            fwd_odd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_move && s1_inc_even_reg)
                fwd_even_valid_reg <= 1'b1;
            if (s1_move && s1_inc_odd_reg)
                fwd_odd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_inc_even_reg)
        begin
            fwd_even_addr_reg <= s1_even_addr_reg;
            fwd_even_data_reg <= even_inc;
        end
        if (s1_move && s1_inc_odd_reg)
        begin
            fwd_odd_addr_reg <= s1_odd_addr_reg;
            fwd_odd_data_reg <= odd_inc;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_payload_reg.even_min   <= s1_even_min_reg;
            out_payload_reg.even_max   <= s1_even_max_reg;
            out_payload_reg.odd_min    <= s1_odd_min_reg;
            out_payload_reg.odd_max    <= s1_odd_max_reg;
            out_payload_reg.pairs_seen <= s1_pairs_reg;
            out_payload_reg.bin_count  <= bin_value;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_payload_reg;

`ifndef SYNTH
    // no item enters while the memories are being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !accept && !s1_valid_reg)
        else $error("item in flight during clearing pass");

    // once a pair is seen each channel's minimum is not above its maximum
    a_extremes_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        pair_total_reg != '0 |-> even_low_reg <= even_high_reg && odd_low_reg <= odd_high_reg)
        else $error("running minimum above running maximum");

    // pair count never decreases
    a_pairs_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> pair_total_reg >= $past(pair_total_reg))
        else $error("pair count went backwards");

    // a stalled stage 1 writes nothing back
    a_no_write_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ch.ready |-> !even_we && !odd_we)
        else $error("histogram written while stage 1 stalled");
`endif

endmodule

`default_nettype wire
